@@ rtl/core/upd_pkg.sv @@
// shared types, constants and a hex decode helper function for the url percent decoder
package upd_pkg;

    localparam int CHAR_W      = 8;
    localparam int BUF_W       = 16;
    localparam int REQ_W       = 16;
    localparam int COUNT_W_DEF = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register index, taken from the word address
    localparam logic REG_BUFFER_SIZE = 1'b0;

    localparam logic [BUF_W-1:0] BUFFER_SIZE_RST = 16'hFFFF;

    localparam logic [CHAR_W-1:0] CHR_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CHR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_TEN     = 8'd10;

    typedef enum logic [1:0] {
        PHASE_NORMAL  = 2'd0,
        PHASE_PERCENT = 2'd1,
        PHASE_HIGH    = 2'd2
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] out_byte;
        logic              is_end;
        logic [REQ_W-1:0]  required_count;
    } result_t;

    // hex digit in either case
    function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_t              h;
        logic [CHAR_W-1:0] tmp;
        h   = '0;
        tmp = '0;
        if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9)
        begin
            tmp = c - CHR_DIGIT_0;
            h.ok = 1'b1;
        end
        else if (c >= CHR_LOWER_A && c <= CHR_LOWER_F)
        begin
            tmp = c - CHR_LOWER_A + HEX_TEN;
            h.ok = 1'b1;
        end
        else if (c >= CHR_UPPER_A && c <= CHR_UPPER_F)
        begin
            tmp = c - CHR_UPPER_A + HEX_TEN;
            h.ok = 1'b1;
        end
        h.val = tmp[3:0];
        return h;
    endfunction

endpackage

@@ rtl/core/upd_in_if.sv @@
// input channel: one encoded character or the end marker per transfer
interface upd_in_if;
    logic                        valid;
    logic                        ready;
    logic [upd_pkg::CHAR_W-1:0]  char_byte;
    logic                        end_of_string;

    modport source (output valid, output char_byte, output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

@@ rtl/core/upd_out_if.sv @@
// output channel: one decoded byte or the terminator per transfer
interface upd_out_if;
    logic                        valid;
    logic                        ready;
    logic [upd_pkg::CHAR_W-1:0]  out_byte;
    logic                        is_end;
    logic [upd_pkg::REQ_W-1:0]   required_count;

    modport source (output valid, output out_byte, output is_end, output required_count,
                    input ready);
    modport sink   (input valid, input out_byte, input is_end, input required_count,
                    output ready);
endinterface

@@ rtl/core/upd_apb_regs.sv @@
// apb configuration register file holding buffer_size
module upd_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [upd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [upd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [upd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [upd_pkg::BUF_W-1:0]        buffer_size
);

    logic [upd_pkg::BUF_W-1:0] buffer_size_reg;
    logic [upd_pkg::BUF_W-1:0] buffer_size_next;
    logic                      sel_buf;

    // word address selects the register
    assign sel_buf = (paddr[2] == upd_pkg::REG_BUFFER_SIZE);
    assign pready  = 1'b1;

    always_comb
    begin
        buffer_size_next = buffer_size_reg;
        if (psel && penable && pwrite && sel_buf)
        begin
            buffer_size_next = pwdata[upd_pkg::BUF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= upd_pkg::BUFFER_SIZE_RST;
        end
        else
        begin
            buffer_size_reg <= buffer_size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_buf)
        begin
            prdata = upd_pkg::APB_DATA_W'(buffer_size_reg);
        end
    end

    assign buffer_size = buffer_size_reg;

endmodule

@@ rtl/core/upd_decode_core.sv @@
// escape state machine, byte counter and per-item decode logic
module upd_decode_core #(
    parameter int COUNT_WIDTH = upd_pkg::COUNT_W_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [upd_pkg::CHAR_W-1:0]   char_byte,
    input  logic                         end_of_string,
    input  logic [upd_pkg::BUF_W-1:0]    buffer_size,
    output upd_pkg::result_t             result
);

    localparam int CmpW = (COUNT_WIDTH > upd_pkg::BUF_W) ? COUNT_WIDTH : upd_pkg::BUF_W;

    upd_pkg::phase_t           phase_reg;
    upd_pkg::phase_t           phase_next;
    logic [3:0]                nibble_reg;
    logic [3:0]                nibble_next;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [COUNT_WIDTH-1:0]    count_next;
    logic [CmpW-1:0]           count_wide;
    logic [CmpW-1:0]           buf_wide;
    upd_pkg::hex_t             hex;
    logic                      plain;
    logic                      put;
    logic [upd_pkg::CHAR_W-1:0] put_val;

    assign count_wide = CmpW'(count_reg);
    assign buf_wide   = CmpW'(buffer_size);
    assign hex        = upd_pkg::hex_decode(char_byte);

    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        count_next  = count_reg;
        result      = '0;
        plain       = 1'b1;
        put         = 1'b0;
        put_val     = char_byte;
        if (end_of_string)
        begin
            result.hit            = 1'b1;
            result.is_end         = 1'b1;
            result.required_count = count_wide[upd_pkg::REQ_W-1:0];
            phase_next            = upd_pkg::PHASE_NORMAL;
            nibble_next           = '0;
            count_next            = COUNT_WIDTH'(1);
        end
        else
        begin
            unique case (phase_reg)
                upd_pkg::PHASE_PERCENT:
                begin
                    if (hex.ok)
                    begin
                        nibble_next = hex.val;
                        phase_next  = upd_pkg::PHASE_HIGH;
                        plain       = 1'b0;
                    end
                end
                upd_pkg::PHASE_HIGH:
                begin
                    if (hex.ok)
                    begin
                        put        = 1'b1;
                        put_val    = {nibble_reg, hex.val};
                        phase_next = upd_pkg::PHASE_NORMAL;
                        plain      = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            // broken escapes fall back to ordinary handling of this character
            if (plain)
            begin
                if (char_byte == upd_pkg::CHR_PERCENT)
                begin
                    phase_next = upd_pkg::PHASE_PERCENT;
                end
                else
                begin
                    phase_next = upd_pkg::PHASE_NORMAL;
                    put        = 1'b1;
                    put_val    = (char_byte == upd_pkg::CHR_PLUS) ? upd_pkg::CHR_SPACE
                                                                  : char_byte;
                end
            end
            if (put)
            begin
                result.hit      = (count_wide < buf_wide);
                result.out_byte = put_val;
                if (!(&count_reg))
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= upd_pkg::PHASE_NORMAL;
            nibble_reg <= '0;
            count_reg  <= COUNT_WIDTH'(1);
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/url_percent_decoder_unit.sv @@
// top level of the url percent decoder: input register, decode core, result register
//
// url percent decoder. takes one encoded character per transfer on char_in and
// gives at most one decoded byte per transfer on byte_out. %XY with hex digits in
// either case becomes one byte, '+' becomes a space, a '%' or a '%' plus one hex
// digit that is not completed by a hex digit is dropped and the breaking character
// is handled normally. a decoded byte is passed on only while the running count
// (starting at 1 for the terminator, saturating at 2^COUNT_WIDTH-1) is below
// buffer_size; it is counted either way. an end_of_string transfer always gives a
// terminator result (out_byte 0, is_end 1, required_count = count mod 2^16) and
// clears the escape state and resets the count to 1 for the next string.
// throughput is one character per clock while byte_out is not stalled; each
// character passes the input register, the single decode stage and the result
// register before its result shows on byte_out; it waits in the input register
// while byte_out stalls. buffer_size sits at byte address 0 of the apb port (reset
// 65535); the user must write it only while the block is idle, not enforced here.
module url_percent_decoder_unit #(
    parameter int COUNT_WIDTH = upd_pkg::COUNT_W_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    upd_in_if.sink                           char_in,
    upd_out_if.source                        byte_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [upd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [upd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [upd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [upd_pkg::BUF_W-1:0]  buffer_size;

    // input register
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [upd_pkg::CHAR_W-1:0] s1_char_reg;
    logic                       s1_end_reg;
    logic                       s1_advance;
    logic                       in_xfer;

    // result register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    upd_pkg::result_t           out_res_reg;
    upd_pkg::result_t           core_res;

    upd_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .buffer_size (buffer_size)
    );

    // the held item moves on when the result register is free or draining
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || byte_out.ready);
    assign char_in.ready = !s1_valid_reg || s1_advance;
    assign in_xfer       = char_in.valid && char_in.ready;

    upd_decode_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_advance),
        .char_byte     (s1_char_reg),
        .end_of_string (s1_end_reg),
        .buffer_size   (buffer_size),
        .result        (core_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // items that decode to nothing still advance, leaving the result slot empty
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = core_res.hit;
        end
        else if (byte_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_char_reg <= char_in.char_byte;
            s1_end_reg  <= char_in.end_of_string;
        end
        if (s1_advance && core_res.hit)
        begin
            out_res_reg <= core_res;
        end
    end

    assign byte_out.valid          = out_valid_reg;
    assign byte_out.out_byte       = out_res_reg.out_byte;
    assign byte_out.is_end         = out_res_reg.is_end;
    assign byte_out.required_count = out_res_reg.required_count;

`ifndef ASSERT_OFF
    // terminator results carry a zero byte
    a_end_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.is_end |-> out_res_reg.out_byte == '0)
        else $error("terminator result with nonzero byte");

    // plain data results carry no count
    a_data_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.is_end |-> out_res_reg.required_count == '0)
        else $error("data result with nonzero count");

    // an end item always lands in the result register
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_end_reg |=> out_valid_reg && out_res_reg.is_end)
        else $error("end item produced no terminator");

    // an accepted transfer is held in the input register
    a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted transfer lost");
`endif

endmodule
